FILE: hdl/spd_pkg.sv
// shared types, codes and constants for the serial packet deframer
// no dependencies

package spd_pkg;

    localparam logic [15:0] HEADER_WORD  = 16'h1BE4;
    localparam logic [15:0] TRAILER_WORD = 16'hE41B;
    localparam logic [7:0]  REPLY_ACK    = 8'h2D;
    localparam logic [7:0]  REPLY_NAK    = 8'hA5;
    localparam logic [7:0]  REPLY_NONE   = 8'h00;

    // parser phase codes
    localparam logic [3:0] PH_HDR_LO = 4'd0;
    localparam logic [3:0] PH_HDR_HI = 4'd1;
    localparam logic [3:0] PH_LEN_LO = 4'd2;
    localparam logic [3:0] PH_LEN_HI = 4'd3;
    localparam logic [3:0] PH_CMD_LO = 4'd4;
    localparam logic [3:0] PH_CMD_HI = 4'd5;
    localparam logic [3:0] PH_DAT_LO = 4'd6;
    localparam logic [3:0] PH_DAT_HI = 4'd7;
    localparam logic [3:0] PH_SUM_LO = 4'd8;
    localparam logic [3:0] PH_SUM_HI = 4'd9;
    localparam logic [3:0] PH_TRL_LO = 4'd10;
    localparam logic [3:0] PH_TRL_HI = 4'd11;

    // result kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // end status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_HEADER   = 2'd1;
    localparam logic [1:0] ST_CHECKSUM = 2'd2;
    localparam logic [1:0] ST_TRAILER  = 2'd3;

    typedef struct packed {
        logic [3:0]  phase;
        logic [7:0]  low_byte_hold;
        logic [15:0] length_word;
        logic [15:0] command_word;
        logic [14:0] words_seen;
        logic [15:0] running_sum;
    } spd_state_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] word_value;
        logic [14:0] word_index;
        logic [15:0] packet_length;
        logic [1:0]  status;
        logic [7:0]  reply_byte;
    } spd_result_t;

endpackage

FILE: hdl/spd_byte_if.sv
// valid/ready channel carrying one received byte per item
// no dependencies

interface spd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: hdl/spd_result_if.sv
// valid/ready channel carrying one deframer result item
// no dependencies

interface spd_result_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] word_value;
    logic [14:0] word_index;
    logic [15:0] packet_length;
    logic [1:0]  status;
    logic [7:0]  reply_byte;

    modport source (output valid, output kind, output word_value, output word_index,
                    output packet_length, output status, output reply_byte,
                    input ready);
    modport sink   (input valid, input kind, input word_value, input word_index,
                    input packet_length, input status, input reply_byte,
                    output ready);
endinterface

FILE: hdl/spd_parser.sv
// per-byte next-state and result logic of the packet deframer
// depends on spd_pkg

module spd_parser
    import spd_pkg::*;
(
    input  spd_state_t  cur,
    input  logic [7:0]  rx_byte,
    output spd_state_t  nxt,
    output logic        res_valid,
    output spd_result_t res
);

    logic [15:0] word;
    logic [14:0] total;
    logic [15:0] sum_next;
    logic [14:0] seen_inc;

    assign word     = {rx_byte, cur.low_byte_hold};
    assign total    = cur.length_word[15:1];
    assign sum_next = cur.running_sum + {8'd0, cur.low_byte_hold} + {8'd0, rx_byte};
    assign seen_inc = cur.words_seen + 15'd1;

    always_comb
    begin
        nxt       = cur;
        res_valid = 1'b0;
        res       = '{kind: KIND_END, word_value: 16'd0, word_index: 15'd0,
                      packet_length: cur.length_word, status: ST_OK,
                      reply_byte: REPLY_NONE};
        unique case (cur.phase)
            PH_HDR_HI:
            begin
                if (word != HEADER_WORD)
                begin
                    res_valid         = 1'b1;
                    res.packet_length = 16'd0;
                    res.status        = ST_HEADER;
                    res.reply_byte    = REPLY_NAK;
                    nxt.phase         = PH_HDR_LO;
                end
                else
                begin
                    nxt.phase = PH_LEN_LO;
                end
            end
            PH_LEN_HI:
            begin
                nxt.length_word = word;
                nxt.running_sum = 16'd0;
                nxt.phase       = PH_CMD_LO;
            end
            PH_CMD_HI:
            begin
                // sum starts from zero here, cleared by the length word
                nxt.command_word = word;
                nxt.running_sum  = sum_next;
                nxt.words_seen   = 15'd0;
                nxt.phase        = (total == 15'd0) ? PH_SUM_LO : PH_DAT_LO;
            end
            PH_DAT_HI:
            begin
                nxt.running_sum = sum_next;
                res_valid       = 1'b1;
                res.kind        = KIND_DATA;
                res.word_value  = word;
                res.word_index  = cur.words_seen;
                nxt.words_seen  = seen_inc;
                nxt.phase       = (seen_inc >= total) ? PH_SUM_LO : PH_DAT_LO;
            end
            PH_SUM_HI:
            begin
                if (word != cur.running_sum)
                begin
                    res_valid      = 1'b1;
                    res.word_value = cur.command_word;
                    res.status     = ST_CHECKSUM;
                    res.reply_byte = REPLY_NAK;
                    nxt.phase      = PH_HDR_LO;
                end
                else
                begin
                    nxt.phase = PH_TRL_LO;
                end
            end
            PH_TRL_HI:
            begin
                res_valid      = 1'b1;
                res.word_value = cur.command_word;
                if (word != TRAILER_WORD)
                begin
                    res.status     = ST_TRAILER;
                    res.reply_byte = REPLY_NAK;
                end
                else
                begin
                    res.status     = ST_OK;
                    res.reply_byte = REPLY_ACK;
                end
                nxt.phase = PH_HDR_LO;
            end
            PH_LEN_LO, PH_CMD_LO, PH_DAT_LO, PH_SUM_LO, PH_TRL_LO:
            begin
                nxt.low_byte_hold = rx_byte;
                nxt.phase         = cur.phase + 4'd1;
            end
            default:
            begin
                // header low byte, and unused codes fall back to hunting
                nxt.low_byte_hold = rx_byte;
                nxt.phase         = PH_HDR_HI;
            end
        endcase
    end

endmodule

FILE: hdl/serial_packet_deframer_checksum_core.sv
// top level of the serial packet deframer with byte-sum checksum
// depends on spd_pkg, spd_byte_if, spd_result_if, spd_parser
//
//  channel  dir  payload                                              item
//  rx       in   rx_byte                                              one received byte
//  res      out  kind word_value word_index packet_length status      data word or end
//                reply_byte
//
// one byte per cycle while no result is stalled; each byte goes through the parser logic in the
// cycle it is accepted and its result, if any, lands in the result register
// rx.ready is high whenever the result register is empty or is taken this cycle
// a stalled result holds the result register and stalls input only while full
// rst_n clears the parser state to hunting a header low byte

module serial_packet_deframer_checksum_core
    import spd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    spd_byte_if.sink            rx,
    spd_result_if.source        res
);

    spd_state_t  state_reg;
    spd_state_t  state_next;
    spd_result_t res_reg;
    spd_result_t res_comb;
    logic        res_valid_reg;
    logic        res_hit;
    logic        rx_fire;

    assign rx.ready = !res_valid_reg || res.ready;
    assign rx_fire  = rx.valid && rx.ready;

    spd_parser u_parser (
        .cur       (state_reg),
        .rx_byte   (rx.rx_byte),
        .nxt       (state_next),
        .res_valid (res_hit),
        .res       (res_comb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{phase: PH_HDR_LO, low_byte_hold: 8'd0, length_word: 16'd0,
                           command_word: 16'd0, words_seen: 15'd0,
                           running_sum: 16'd0};
        end
        else if (rx_fire)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            res_valid_reg <= rx_fire && res_hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_fire && res_hit)
        begin
            res_reg <= res_comb;
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.kind          = res_reg.kind;
    assign res.word_value    = res_reg.word_value;
    assign res.word_index    = res_reg.word_index;
    assign res.packet_length = res_reg.packet_length;
    assign res.status        = res_reg.status;
    assign res.reply_byte    = res_reg.reply_byte;

endmodule
